// ===== design/brp_pkg.sv =====
// Shared types and constants for the boot response parser.
// No dependencies; the design modules and the testbench import this package.
package brp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [7:0] ID_STATUS   = 8'h01;
  localparam logic [7:0] ID_CHUNK    = 8'h02;
  localparam logic [7:0] ID_ERASE    = 8'h03;
  localparam logic [7:0] ID_CHUNKERR = 8'h04;
  localparam logic [7:0] ID_SIZE_SET = 8'hAA;

  localparam logic [7:0] DATA_ERASE_FAIL = 8'd1;
  localparam logic [7:0] DATA_ERASE_DONE = 8'd2;
  localparam logic [7:0] DATA_FLASH_OK   = 8'd4;
  localparam logic [7:0] DATA_JUMP_FAIL  = 8'd5;
  localparam logic [7:0] DATA_LEN_WRONG  = 8'd6;
  localparam logic [7:0] DATA_SIZE_SMALL = 8'd1;
  localparam logic [7:0] DATA_SIZE_LARGE = 8'd2;

  localparam logic [2:0] KIND_STATUS   = 3'd0;
  localparam logic [2:0] KIND_CHUNK    = 3'd1;
  localparam logic [2:0] KIND_ERASE    = 3'd2;
  localparam logic [2:0] KIND_CHUNKERR = 3'd3;
  localparam logic [2:0] KIND_SIZE_SET = 3'd4;
  localparam logic [2:0] KIND_OTHER    = 3'd5;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd6;

  localparam logic [2:0] STAT_NONE       = 3'd0;
  localparam logic [2:0] STAT_ERASE_FAIL = 3'd1;
  localparam logic [2:0] STAT_ERASE_DONE = 3'd2;
  localparam logic [2:0] STAT_FLASH_OK   = 3'd3;
  localparam logic [2:0] STAT_JUMP_FAIL  = 3'd4;
  localparam logic [2:0] STAT_LEN_WRONG  = 3'd5;

  localparam logic [11:0] SIZE_SMALL = 12'd1024;
  localparam logic [11:0] SIZE_LARGE = 12'd2048;

  localparam logic [7:0] TICK_LIMIT_RESET = 8'd20;
  localparam logic [7:0] IDLE_TICKS_MAX   = 8'd255;
  localparam logic [6:0] PERCENT_MAX      = 7'd100;

  localparam logic REG_FILE_LENGTH = 1'b0;
  localparam logic REG_TICK_LIMIT  = 1'b1;

  localparam int FILE_LEN_W = 24;
  localparam int OFFSET_W   = 19;
  localparam int CHUNK_W    = 12;
  localparam int NUM_W      = 20;
  localparam int DVD_W      = 27;
  localparam int DIV_CNT_W  = 5;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // One job handed from the parser to the decoder.
  typedef struct packed {
    logic       is_timeout;
    logic [7:0] id;
    logic [7:0] data;
  } brp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brp_fifo_stat_t;

endpackage

// ===== design/brp_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
// No dependencies; the field widths are written out as literals.
interface brp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

interface brp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  status_code;
  logic [7:0]  frame_id_out;
  logic [7:0]  frame_data_out;
  logic [18:0] chunk_offset;
  logic [11:0] chunk_length;
  logic [6:0]  percent;
  logic        send_flash_cmd;
  logic        finished;
  modport source (output valid, kind, status_code, frame_id_out, frame_data_out,
                  chunk_offset, chunk_length, percent, send_flash_cmd, finished,
                  input ready);
  modport sink (input valid, kind, status_code, frame_id_out, frame_data_out,
                chunk_offset, chunk_length, percent, send_flash_cmd, finished,
                output ready);
endinterface

interface brp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/brp_front.sv =====
// Front end: frame sync, Fletcher-style check (two 8-bit sums) and response timer.
// Depends on brp_pkg and brp_in_if; pushes jobs into brp_fifo.
module brp_front
  import brp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  brp_in_if.sink         in_ch,
  input  logic [7:0]     tick_limit,
  input  brp_fifo_stat_t fifo_stat,
  output logic           push,
  output brp_job_t       push_job
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SUMA  = 3'd4;
  localparam logic [2:0] PH_SUMB  = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] rsum_a_r, rsum_a_nxt;
  logic       resp_r, resp_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       run_r, run_nxt;
  logic       accept;

  assign in_ch.ready = !fifo_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0] sa;
    sa         = sum_a_r + in_ch.rx_byte;
    phase_nxt  = phase_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    id_nxt     = id_r;
    data_nxt   = data_r;
    rsum_a_nxt = rsum_a_r;
    resp_nxt   = resp_r;
    idle_nxt   = idle_r;
    run_nxt    = run_r;
    push       = 1'b0;
    push_job   = '0;
    if (accept && in_ch.func) begin
      if (run_r) begin
        if (resp_r) begin
          idle_nxt = '0;
          resp_nxt = 1'b0;
        end else if (idle_r != IDLE_TICKS_MAX) begin
          idle_nxt = idle_r + 8'd1;
        end
        if (idle_nxt >= tick_limit) begin
          idle_nxt            = '0;
          resp_nxt            = 1'b0;
          run_nxt             = 1'b0;
          push                = 1'b1;
          push_job.is_timeout = 1'b1;
        end
      end
    end else if (accept) begin
      case (phase_r)
        PH_SYNC1: begin
          if (in_ch.rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_nxt = (in_ch.rx_byte == SYNC_SECOND) ? PH_ID : PH_SYNC1;
        end
        PH_ID: begin
          id_nxt    = in_ch.rx_byte;
          sum_a_nxt = sa;
          sum_b_nxt = sum_b_r + sa;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          data_nxt  = in_ch.rx_byte;
          sum_a_nxt = sa;
          sum_b_nxt = sum_b_r + sa;
          phase_nxt = PH_SUMA;
        end
        PH_SUMA: begin
          rsum_a_nxt = in_ch.rx_byte;
          phase_nxt  = PH_SUMB;
        end
        PH_SUMB: begin
          phase_nxt  = PH_SYNC1;
          sum_a_nxt  = '0;
          sum_b_nxt  = '0;
          rsum_a_nxt = '0;
          if (sum_a_r == rsum_a_r && sum_b_r == in_ch.rx_byte) begin
            resp_nxt      = 1'b1;
            push          = 1'b1;
            push_job.id   = id_r;
            push_job.data = data_r;
            if (id_r == ID_STATUS && data_r == DATA_FLASH_OK) run_nxt = 1'b0;
          end
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      id_r     <= '0;
      data_r   <= '0;
      rsum_a_r <= '0;
      resp_r   <= 1'b0;
      idle_r   <= '0;
      run_r    <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      id_r     <= id_nxt;
      data_r   <= data_nxt;
      rsum_a_r <= rsum_a_nxt;
      resp_r   <= resp_nxt;
      idle_r   <= idle_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

// ===== design/brp_fifo.sv =====
// Small job queue between the parser front end and the decoder.
// Depends on brp_pkg for the job type and depth.
module brp_fifo
  import brp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  brp_job_t       push_job,
  input  logic           pop,
  output brp_job_t       head_job,
  output brp_fifo_stat_t stat
);

  brp_job_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/brp_back.sv =====
// Back end: decodes jobs into results, percent through a restoring divider.
// Depends on brp_pkg and brp_out_if; pops jobs from brp_fifo.
module brp_back
  import brp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  brp_job_t              head_job,
  input  brp_fifo_stat_t        fifo_stat,
  output logic                  pop,
  input  logic [FILE_LEN_W-1:0] file_length,
  brp_out_if.source             out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  brp_job_t              job_r;
  logic [CHUNK_W-1:0]    csize_r;
  logic [2:0]            kind_r, code_r;
  logic [7:0]            oid_r, odata_r;
  logic [OFFSET_W-1:0]   off_r;
  logic [CHUNK_W-1:0]    len_r;
  logic [6:0]            pct_r;
  logic                  flash_r, fin_r;
  logic [FILE_LEN_W-1:0] rem_r;
  logic [DVD_W-1:0]      quo_r;
  logic [DIV_CNT_W-1:0]  cnt_r;

  // chunk math
  logic [NUM_W-1:0]      prod;
  logic [OFFSET_W-1:0]   offset;
  logic [FILE_LEN_W-1:0] remain;
  logic [CHUNK_W-1:0]    len;
  logic [NUM_W-1:0]      num;
  logic [DVD_W-1:0]      dividend;
  logic                  need_div;
  logic [2:0]            kind_c, code_c;

  // divider step
  logic [FILE_LEN_W:0]   shifted;
  logic                  q_bit;

  assign pop = (state_r == ST_IDLE) && !fifo_stat.empty;

  assign prod   = NUM_W'(job_r.data) * NUM_W'(csize_r);
  assign offset = prod[OFFSET_W-1:0];
  assign remain = file_length - FILE_LEN_W'(offset);

  always_comb begin
    if (file_length > FILE_LEN_W'(offset)) begin
      len = (remain > FILE_LEN_W'(csize_r)) ? csize_r : remain[CHUNK_W-1:0];
    end else begin
      len = '0;
    end
    num = (job_r.id == ID_CHUNK) ? NUM_W'(offset) + NUM_W'(len) : prod;
  end

  assign dividend = DVD_W'(num) * DVD_W'(PERCENT_MAX);
  assign need_div = !job_r.is_timeout && (job_r.id == ID_CHUNK || job_r.id == ID_ERASE)
                    && (file_length != '0);

  always_comb begin
    code_c = STAT_NONE;
    case (job_r.data)
      DATA_ERASE_FAIL: code_c = STAT_ERASE_FAIL;
      DATA_ERASE_DONE: code_c = STAT_ERASE_DONE;
      DATA_FLASH_OK:   code_c = STAT_FLASH_OK;
      DATA_JUMP_FAIL:  code_c = STAT_JUMP_FAIL;
      DATA_LEN_WRONG:  code_c = STAT_LEN_WRONG;
      default:         code_c = STAT_NONE;
    endcase
    case (job_r.id)
      ID_STATUS:   kind_c = KIND_STATUS;
      ID_CHUNK:    kind_c = KIND_CHUNK;
      ID_ERASE:    kind_c = KIND_ERASE;
      ID_CHUNKERR: kind_c = KIND_CHUNKERR;
      ID_SIZE_SET: kind_c = KIND_SIZE_SET;
      default:     kind_c = KIND_OTHER;
    endcase
  end

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign q_bit   = (shifted >= {1'b0, file_length});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop) state_nxt = ST_CALC;
      ST_CALC: state_nxt = need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      csize_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC && !job_r.is_timeout && job_r.id == ID_SIZE_SET) begin
        if (job_r.data == DATA_SIZE_SMALL) csize_r <= SIZE_SMALL;
        else if (job_r.data == DATA_SIZE_LARGE) csize_r <= SIZE_LARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head_job;
    if (state_r == ST_CALC) begin
      rem_r   <= '0;
      quo_r   <= dividend;
      cnt_r   <= DIV_CNT_W'(DVD_W - 1);
      pct_r   <= '0;
      off_r   <= '0;
      len_r   <= '0;
      code_r  <= STAT_NONE;
      flash_r <= 1'b0;
      fin_r   <= 1'b0;
      if (job_r.is_timeout) begin
        kind_r  <= KIND_TIMEOUT;
        oid_r   <= '0;
        odata_r <= '0;
        fin_r   <= 1'b1;
      end else begin
        kind_r  <= kind_c;
        oid_r   <= job_r.id;
        odata_r <= job_r.data;
        if (job_r.id == ID_STATUS) begin
          code_r  <= code_c;
          flash_r <= (code_c == STAT_FLASH_OK);
          fin_r   <= (code_c == STAT_FLASH_OK);
        end
        if (job_r.id == ID_CHUNK) begin
          off_r <= offset;
          len_r <= len;
        end
      end
    end else if (state_r == ST_DIV) begin
      rem_r <= q_bit ? FILE_LEN_W'(shifted - {1'b0, file_length})
                     : shifted[FILE_LEN_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        // last quotient bit lands here; saturate the full quotient
        if ({quo_r[DVD_W-2:0], q_bit} > DVD_W'(PERCENT_MAX)) pct_r <= PERCENT_MAX;
        else pct_r <= {quo_r[5:0], q_bit};
      end
    end
  end

  assign out_ch.valid          = (state_r == ST_OUT);
  assign out_ch.kind           = kind_r;
  assign out_ch.status_code    = code_r;
  assign out_ch.frame_id_out   = oid_r;
  assign out_ch.frame_data_out = odata_r;
  assign out_ch.chunk_offset   = off_r;
  assign out_ch.chunk_length   = len_r;
  assign out_ch.percent        = pct_r;
  assign out_ch.send_flash_cmd = flash_r;
  assign out_ch.finished       = fin_r;

endmodule

// ===== design/boot_response_parser.sv =====
// Top level of the boot response parser: configuration registers and wiring.
// Depends on brp_pkg, brp_if, brp_front, brp_fifo and brp_back.
//
//  channel | dir | beat fields               | handshake
//  in_ch   | in  | func, rx_byte             | valid/ready
//  out_ch  | out | kind .. finished (9)      | valid/ready
//  cfg_ch  | in  | index, data               | valid/ready, ready tied high
//
// A byte or tick beat is taken each cycle while the 4-entry job queue has room.
// Each frame or timeout result passes through the decoder states idle, calc and out,
// one job at a time; chunk request and erase progress also pass through the 27-step
// restoring divider for percent when file_length is nonzero.
// rst_n is synchronous, active low; it clears the parser, arms the timer, clears
// the chunk size and loads file_length 0 and tick_limit 20.
// A stalled out_ch holds the decoder; the front keeps parsing until the queue fills.
module boot_response_parser
  import brp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  brp_in_if.sink    in_ch,
  brp_out_if.source out_ch,
  brp_cfg_if.sink   cfg_ch
);

  logic [FILE_LEN_W-1:0] file_length_r;
  logic [7:0]            tick_limit_r;
  logic                  push, pop;
  brp_job_t              push_job, head_job;
  brp_fifo_stat_t        fifo_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      tick_limit_r  <= TICK_LIMIT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_FILE_LENGTH: file_length_r <= cfg_ch.data;
        REG_TICK_LIMIT:  tick_limit_r  <= cfg_ch.data[7:0];
        default:         ;
      endcase
    end
  end

  brp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .tick_limit (tick_limit_r),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_job   (push_job)
  );

  brp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  brp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .fifo_stat   (fifo_stat),
    .pop         (pop),
    .file_length (file_length_r),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("job popped from empty queue");

  a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_TIMEOUT) |->
      (out_ch.finished && out_ch.frame_id_out == 8'd0 && !out_ch.send_flash_cmd))
    else $error("timeout result carries frame fields");

  a_flash_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.send_flash_cmd) |->
      (out_ch.kind == KIND_STATUS && out_ch.status_code == STAT_FLASH_OK
       && out_ch.finished))
    else $error("flash command outside flash ok status");
`endif

endmodule

// ===== verif/tb_boot_response_parser.sv =====
// Testbench for boot_response_parser: drives byte and tick beats, predicts every result
// in-line and checks the result channel field by field. Needs brp_pkg, brp_if and the RTL.
module tb_boot_response_parser;
  import brp_pkg::*;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 30;

  typedef enum logic [2:0] {HUNT, SYNC2, GET_ID, GET_DATA, GET_SUM_A, GET_SUM_B} parse_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx;
  } beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  status_code;
    logic [7:0]  frame_id;
    logic [7:0]  frame_data;
    logic [18:0] chunk_offset;
    logic [11:0] chunk_length;
    logic [6:0]  percent;
    logic        send_flash_cmd;
    logic        finished;
  } resp_t;

  logic clk;
  logic rst_n;

  brp_in_if  in_ch();
  brp_out_if out_ch();
  brp_cfg_if cfg_ch();

  boot_response_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Parser mirror
  parse_t      prs;
  logic [7:0]  sum_a_q, sum_b_q, id_q, data_q, rx_sum_a_q;
  logic [11:0] chunk_sz;
  logic        got_resp;
  logic [7:0]  idle_cnt;
  logic        tmr_run;
  logic [23:0] file_len;
  logic [7:0]  tick_lim;

  beat_t pending[$];
  resp_t frame_results[$];

  int errors = 0;
  int n_queued = 0;
  int n_beats = 0;
  int n_results = 0;
  int n_timeouts = 0;
  int n_writes = 0;
  int cycles = 0;

  logic        in_taken;
  beat_t       next_beat;
  int          burst_left = 1;
  int          gap_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [5:0]  pat_cnt = '0;
  resp_t       want_r;
  int          tlim_final;

  function automatic logic [6:0] progress_pct(input logic [63:0] num);
    logic [63:0] p;
    if (file_len == '0) return '0;
    p = num * 100 / 64'(file_len);
    return (p > 64'(PERCENT_MAX)) ? PERCENT_MAX : p[6:0];
  endfunction

  task automatic take_beat(input beat_t bt);
    resp_t       r;
    logic [63:0] off;
    logic [63:0] len;
    r = '0;
    if (bt.func == FUNC_TICK) begin
      if (tmr_run) begin
        if (got_resp) begin
          idle_cnt = '0;
          got_resp = 1'b0;
        end else if (idle_cnt < IDLE_TICKS_MAX) begin
          idle_cnt = idle_cnt + 8'd1;
        end
        if (idle_cnt >= tick_lim) begin
          got_resp = 1'b0;
          tmr_run = 1'b0;
          idle_cnt = '0;
          r.kind = KIND_TIMEOUT;
          r.finished = 1'b1;
          frame_results.push_back(r);
          n_timeouts++;
        end
      end
    end else begin
      case (prs)
        HUNT: if (bt.rx == SYNC_FIRST) prs = SYNC2;
        SYNC2: prs = (bt.rx == SYNC_SECOND) ? GET_ID : HUNT;
        GET_ID: begin
          id_q = bt.rx;
          sum_a_q = sum_a_q + bt.rx;
          sum_b_q = sum_b_q + sum_a_q;
          prs = GET_DATA;
        end
        GET_DATA: begin
          data_q = bt.rx;
          sum_a_q = sum_a_q + bt.rx;
          sum_b_q = sum_b_q + sum_a_q;
          prs = GET_SUM_A;
        end
        GET_SUM_A: begin
          rx_sum_a_q = bt.rx;
          prs = GET_SUM_B;
        end
        default: begin
          if (sum_a_q == rx_sum_a_q && sum_b_q == bt.rx) begin
            got_resp = 1'b1;
            r.frame_id = id_q;
            r.frame_data = data_q;
            case (id_q)
              ID_STATUS: begin
                r.kind = KIND_STATUS;
                case (data_q)
                  DATA_ERASE_FAIL: r.status_code = STAT_ERASE_FAIL;
                  DATA_ERASE_DONE: r.status_code = STAT_ERASE_DONE;
                  DATA_FLASH_OK: begin
                    r.status_code = STAT_FLASH_OK;
                    r.send_flash_cmd = 1'b1;
                    r.finished = 1'b1;
                    tmr_run = 1'b0;
                  end
                  DATA_JUMP_FAIL: r.status_code = STAT_JUMP_FAIL;
                  DATA_LEN_WRONG: r.status_code = STAT_LEN_WRONG;
                  default: r.status_code = STAT_NONE;
                endcase
              end
              ID_CHUNK: begin
                r.kind = KIND_CHUNK;
                off = 64'(data_q) * 64'(chunk_sz);
                if (64'(file_len) > off) begin
                  len = 64'(file_len) - off;
                  if (len > 64'(chunk_sz)) len = 64'(chunk_sz);
                end else begin
                  len = '0;
                end
                r.chunk_offset = off[18:0];
                r.chunk_length = len[11:0];
                r.percent = progress_pct(off + len);
              end
              ID_ERASE: begin
                r.kind = KIND_ERASE;
                r.percent = progress_pct(64'(data_q) * 64'(chunk_sz));
              end
              ID_CHUNKERR: r.kind = KIND_CHUNKERR;
              ID_SIZE_SET: begin
                r.kind = KIND_SIZE_SET;
                if (data_q == DATA_SIZE_SMALL) chunk_sz = SIZE_SMALL;
                else if (data_q == DATA_SIZE_LARGE) chunk_sz = SIZE_LARGE;
              end
              default: r.kind = KIND_OTHER;
            endcase
            frame_results.push_back(r);
          end
          prs = HUNT;
          sum_a_q = '0;
          sum_b_q = '0;
          rx_sum_a_q = '0;
        end
      endcase
    end
  endtask

  // Accept side of the input channel; the mirror advances on every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      prs = HUNT;
      sum_a_q = '0;
      sum_b_q = '0;
      id_q = '0;
      data_q = '0;
      rx_sum_a_q = '0;
      chunk_sz = '0;
      got_resp = 1'b0;
      idle_cnt = '0;
      tmr_run = 1'b1;
      file_len = '0;
      tick_lim = TICK_LIMIT_RESET;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        take_beat(beat_t'{in_ch.func, in_ch.rx_byte});
        n_beats++;
      end
    end
  end

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() != 0) begin
        next_beat = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= next_beat.func;
        in_ch.rx_byte <= next_beat.rx;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: a 16-bit ready pattern, redrawn each time its 6-bit index counter wraps
  always @(negedge clk) begin
    if (pat_cnt == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom) | 16'h0001;
        2: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h0001;
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
    end
    out_ch.ready <= stall_pat[pat_cnt[3:0]];
    pat_cnt = pat_cnt + 6'd1;
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (frame_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d id %0d data %0d",
                   $time, out_ch.kind, out_ch.frame_id_out, out_ch.frame_data_out);
      end else begin
        want_r = frame_results.pop_front();
        check_field("kind", want_r.kind, out_ch.kind);
        check_field("status_code", want_r.status_code, out_ch.status_code);
        check_field("frame_id_out", want_r.frame_id, out_ch.frame_id_out);
        check_field("frame_data_out", want_r.frame_data, out_ch.frame_data_out);
        check_field("chunk_offset", want_r.chunk_offset, out_ch.chunk_offset);
        check_field("chunk_length", want_r.chunk_length, out_ch.chunk_length);
        check_field("percent", want_r.percent, out_ch.percent);
        check_field("send_flash_cmd", want_r.send_flash_cmd, out_ch.send_flash_cmd);
        check_field("finished", want_r.finished, out_ch.finished);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycles, frame_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] v);
    pending.push_back(beat_t'{FUNC_BYTE, v});
    n_queued++;
  endtask

  task automatic push_tick();
    pending.push_back(beat_t'{FUNC_TICK, 8'($urandom)});
    n_queued++;
  endtask

  // bad: 0 good sums, 1 corrupt sum A, 2 corrupt sum B
  task automatic push_frame(input logic [7:0] id, input logic [7:0] dat, input int bad);
    logic [7:0] ca;
    logic [7:0] cb;
    ca = id + dat;
    cb = id + ca;
    if (bad == 1) ca = ca ^ 8'($urandom_range(1, 255));
    if (bad == 2) cb = cb ^ 8'($urandom_range(1, 255));
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_byte(id);
    push_byte(dat);
    push_byte(ca);
    push_byte(cb);
  endtask

  task automatic mixed_traffic(input int n, input int tick_pct, input bit allow_flash);
    int         start;
    int         pick;
    logic [7:0] id;
    logic [7:0] dat;
    start = n_queued;
    while (n_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
        push_tick();
      end else if (pick < tick_pct + 6) begin
        push_byte(($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom));
      end else if (pick < tick_pct + 10) begin
        // truncated frame; the following sync may land in any parse state
        push_byte(SYNC_FIRST);
        push_byte($urandom_range(0, 1) ? SYNC_SECOND : 8'($urandom));
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1: id = ID_STATUS;
          2, 3, 4: id = ID_CHUNK;
          5, 6: id = ID_ERASE;
          7: id = ID_CHUNKERR;
          8: id = ID_SIZE_SET;
          default: id = 8'($urandom);
        endcase
        dat = 8'($urandom);
        if (id == ID_STATUS && $urandom_range(0, 3) != 0) dat = 8'($urandom_range(0, 7));
        if ((id == ID_CHUNK || id == ID_ERASE) && $urandom_range(0, 1) == 0)
          dat = 8'($urandom_range(0, 12));
        if (id == ID_SIZE_SET && $urandom_range(0, 3) != 0)
          dat = $urandom_range(0, 1) ? DATA_SIZE_SMALL : DATA_SIZE_LARGE;
        // flash ok stops the timer for good, so keep it for the late phases
        if (!allow_flash && id == ID_STATUS && dat == DATA_FLASH_OK) dat = DATA_JUMP_FAIL;
        push_frame(id, dat, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
      end
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_ch.valid || frame_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_FILE_LENGTH) file_len = v;
    else tick_lim = v[7:0];
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FILE_LENGTH;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: chunk size unset, file length zero
    push_frame(ID_CHUNK, 8'd3, 0);
    push_tick();
    settle();

    write_reg(REG_FILE_LENGTH, 24'hFFFFFF);
    write_reg(REG_TICK_LIMIT, 24'd255);
    push_frame(ID_SIZE_SET, DATA_SIZE_LARGE, 0);
    push_frame(ID_CHUNK, 8'hFF, 0);
    // repeated first sync drops back to hunting
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    push_frame(ID_ERASE, 8'hFF, 2);
    push_frame(ID_SIZE_SET, 8'h07, 0);
    settle();

    write_reg(REG_FILE_LENGTH, 24'($urandom_range(1, 30000)));
    mixed_traffic(350, 5, 1'b0);
    settle();

    write_reg(REG_FILE_LENGTH, 24'd1);
    mixed_traffic(250, 5, 1'b0);
    settle();

    write_reg(REG_FILE_LENGTH, 24'($urandom));
    mixed_traffic(300, 5, 1'b0);
    settle();

    write_reg(REG_FILE_LENGTH, 24'd0);
    mixed_traffic(250, 5, 1'b0);
    settle();

    // tick-heavy traffic under a short limit; the timer stops after the first timeout
    tlim_final = $urandom_range(0, 1) ? 0 : $urandom_range(2, 6);
    write_reg(REG_FILE_LENGTH, 24'($urandom_range(1, 30000)));
    write_reg(REG_TICK_LIMIT, 24'(tlim_final));
    mixed_traffic(350, 25, 1'b1);
    settle();

    write_reg(REG_FILE_LENGTH, 24'hFFFFFF);
    write_reg(REG_TICK_LIMIT, 24'd1);
    mixed_traffic(350, 15, 1'b1);
    settle();

    $display("%0d beats accepted, %0d results checked, %0d timeouts, %0d register writes",
             n_beats, n_results, n_timeouts, n_writes);
    $display("file lengths 0, 1, max and random; final tick limit %0d then 1", tlim_final);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
